/* design/pulse_flow_meter_macros.svh */
// Assertion macros used by the pulse flow meter top level.
`ifndef PULSE_FLOW_METER_MACROS_SVH
`define PULSE_FLOW_METER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pulse_flow_meter: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pulse_flow_meter: next-cycle check failed");

`endif

/* design/pfm_pkg.sv */
// Types and constants shared by the pulse flow meter modules.
package pfm_pkg;

    localparam int EDGE_W     = 4;
    localparam int CAL_W      = 16;
    localparam int PER_W      = 16;
    localparam int SAVE_W     = 17;
    localparam int PULSE_W    = 32;
    localparam int FLOW_W     = 32;
    localparam int SESS_W     = 40;
    localparam int TOT_W      = 48;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int DEN_W      = 32;
    localparam int RATE_DVD_W = 62;
    localparam int VOL_DVD_W  = 56;
    localparam int QUO_W      = 48;
    localparam int CNT_W      = 6;

    // Scale factors that turn pulses into milli-LPM and microliters.
    localparam logic [29:0] RATE_SCALE = 30'd600000000;
    localparam logic [23:0] VOL_SCALE  = 24'd10000000;

    localparam logic [CNT_W-1:0] RATE_STEPS = 6'd32;
    localparam logic [CNT_W-1:0] VOL_STEPS  = 6'd48;

    localparam logic [CAL_W-1:0]  CAL_RESET    = 16'd4500;
    localparam logic [PER_W-1:0]  PERIOD_RESET = 16'd1000;
    localparam logic [SAVE_W-1:0] SAVE_RESET   = 17'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL    = 2'd0,
        CFG_PERIOD = 2'd1,
        CFG_SAVE   = 2'd2,
        CFG_INIT   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        DIV_RATE = 1'b0,
        DIV_VOL  = 1'b1
    } t_div_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RATE_LOAD,
        S_RATE_DIV,
        S_VOL_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic     load_item;
        logic     sample_zero;
        logic     mult;
        logic     div_load;
        t_div_sel div_sel;
        logic     div_step;
        logic     rate_wb;
        logic     vol_wb;
        logic     publish;
    } t_dp_cmd;

    typedef struct packed {
        logic sample_due;
        logic pulses_nz;
        logic div_done;
    } t_dp_sts;

endpackage

/* design/pulse_flow_meter.sv */
// Top level of the pulse flow meter: controller, datapath and checks.
//
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_pulse_edges, i_start_req, i_reset_session,
//                                                i_finalize
// out       output     o_out_valid / i_out_ready o_flow_milli_lpm, o_session_ul, o_total_ul,
//                                                o_is_flowing, o_save_request, o_sample_taken
// cfg       input      i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// A request that closes no sample, or closes one without pulses, passes only through
// the evaluate and finish states. A sample with pulses goes on through the shared one-bit-per-cycle divider
// (32 steps for the flow rate, 48 for the volume).
// Reset is synchronous and restores the register defaults and clears all counters.
// A finished result waits in the output register; the next request is accepted
// meanwhile and stalls only at its end until the output register frees.
`include "pulse_flow_meter_macros.svh"

module pulse_flow_meter import pfm_pkg::*; #(
    parameter int unsigned DEFAULT_CAL_TENTHS = 4500
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [EDGE_W-1:0]    i_pulse_edges,
    input  logic                 i_start_req,
    input  logic                 i_reset_session,
    input  logic                 i_finalize,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FLOW_W-1:0]    o_flow_milli_lpm,
    output logic [SESS_W-1:0]    o_session_ul,
    output logic [TOT_W-1:0]     o_total_ul,
    output logic                 o_is_flowing,
    output logic                 o_save_request,
    output logic                 o_sample_taken
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pfm_datapath #(
        .DEFAULT_CAL_TENTHS (DEFAULT_CAL_TENTHS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_pulse_edges    (i_pulse_edges),
        .i_start_req      (i_start_req),
        .i_reset_session  (i_reset_session),
        .i_finalize       (i_finalize),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_flow_milli_lpm (o_flow_milli_lpm),
        .o_session_ul     (o_session_ul),
        .o_total_ul       (o_total_ul),
        .o_is_flowing     (o_is_flowing),
        .o_save_request   (o_save_request),
        .o_sample_taken   (o_sample_taken)
    );

    `PFM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `PFM_ASSERT_IMPL(a_publish_slot_free, i_clk, i_rst_n, cmd.publish, !o_out_valid || i_out_ready)
    `PFM_ASSERT_IMPL(a_no_step_when_done, i_clk, i_rst_n, cmd.div_step, !sts.div_done)
    `PFM_ASSERT_IMPL(a_single_phase, i_clk, i_rst_n, 1'b1,
        $onehot0({cmd.load_item, cmd.sample_zero, cmd.mult, cmd.vol_wb, cmd.publish}))

endmodule

/* design/pfm_datapath.sv */
// Datapath of the pulse flow meter: configuration, counters, totals and shared divider.
module pfm_datapath import pfm_pkg::*; #(
    parameter int unsigned DEFAULT_CAL_TENTHS = 4500
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [EDGE_W-1:0]    i_pulse_edges,
    input  logic                 i_start_req,
    input  logic                 i_reset_session,
    input  logic                 i_finalize,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [FLOW_W-1:0]    o_flow_milli_lpm,
    output logic [SESS_W-1:0]    o_session_ul,
    output logic [TOT_W-1:0]     o_total_ul,
    output logic                 o_is_flowing,
    output logic                 o_save_request,
    output logic                 o_sample_taken
);

    logic [CAL_W-1:0]  r_cfg_cal;
    logic [PER_W-1:0]  r_cfg_period;
    logic [SAVE_W-1:0] r_cfg_save;
    logic [TOT_W-1:0]  r_cfg_init;

    logic [PULSE_W-1:0] r_pending, n_pending;
    logic [PER_W-1:0]   r_ms_sample, n_ms_sample;
    logic [SAVE_W-1:0]  r_ms_save, n_ms_save;
    logic [FLOW_W-1:0]  r_flow, n_flow;
    logic [SESS_W-1:0]  r_session, n_session;
    logic [TOT_W-1:0]   r_total, n_total;
    logic               r_flowing, n_flowing;
    logic               r_save, n_save;
    logic               r_sampled, n_sampled;
    logic               r_final, n_final;

    logic [RATE_DVD_W-1:0] r_rate_dvd;
    logic [VOL_DVD_W-1:0]  r_vol_dvd;
    logic [DEN_W-1:0]      r_denom;
    logic [DEN_W-1:0]      r_rem;
    logic [DEN_W-1:0]      r_div;
    logic [QUO_W-1:0]      r_quo;
    logic                  r_ovf;
    logic [CNT_W-1:0]      r_cnt;

    logic [FLOW_W-1:0] r_o_flow;
    logic [SESS_W-1:0] r_o_session;
    logic [TOT_W-1:0]  r_o_total;
    logic              r_o_flowing;
    logic              r_o_save;
    logic              r_o_sampled;

    logic [CAL_W-1:0]      cal_eff;
    logic                  clr;
    logic [PULSE_W-1:0]    pend0;
    logic [PULSE_W:0]      pend_sum;
    logic [PER_W-1:0]      mss0;
    logic [SAVE_W-1:0]     mssv0;
    logic [RATE_DVD_W-1:0] rate_prod;
    logic [VOL_DVD_W-1:0]  vol_prod;
    logic [DEN_W-1:0]      den_prod;
    logic [DEN_W:0]        trial;
    logic [DEN_W:0]        diff;
    logic                  ge;
    logic [TOT_W:0]        sess_sum;
    logic [TOT_W:0]        tot_sum;

    assign cal_eff = (r_cfg_cal == '0) ? CAL_W'(DEFAULT_CAL_TENTHS) : r_cfg_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cal    <= CAL_RESET;
            r_cfg_period <= PERIOD_RESET;
            r_cfg_save   <= SAVE_RESET;
            r_cfg_init   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAL:    r_cfg_cal    <= i_cfg_data[CAL_W-1:0];
                CFG_PERIOD: r_cfg_period <= i_cfg_data[PER_W-1:0];
                CFG_SAVE:   r_cfg_save   <= i_cfg_data[SAVE_W-1:0];
                CFG_INIT:   r_cfg_init   <= i_cfg_data[TOT_W-1:0];
                default:    r_cfg_init   <= r_cfg_init;
            endcase
        end
    end

    assign clr      = i_start_req | i_reset_session;
    assign pend0    = clr ? '0 : r_pending;
    assign pend_sum = {1'b0, pend0} + (PULSE_W + 1)'(i_pulse_edges);
    assign mss0     = i_start_req ? '0 : r_ms_sample;
    assign mssv0    = i_start_req ? '0 : r_ms_save;
    assign sess_sum = {{(TOT_W - SESS_W + 1){1'b0}}, r_session} + {1'b0, r_quo};
    assign tot_sum  = {1'b0, r_total} + {1'b0, r_quo};

    always_comb begin
        n_pending   = r_pending;
        n_ms_sample = r_ms_sample;
        n_ms_save   = r_ms_save;
        n_flow      = r_flow;
        n_session   = r_session;
        n_total     = r_total;
        n_flowing   = r_flowing;
        n_save      = r_save;
        n_sampled   = r_sampled;
        n_final     = r_final;
        if (i_cmd.load_item) begin
            n_total     = i_start_req ? r_cfg_init : r_total;
            n_pending   = pend_sum[PULSE_W] ? '1 : pend_sum[PULSE_W-1:0];
            n_ms_sample = (&mss0) ? mss0 : mss0 + 1'b1;
            n_ms_save   = (&mssv0) ? mssv0 : mssv0 + 1'b1;
            n_flow      = clr ? '0 : r_flow;
            n_session   = clr ? '0 : r_session;
            n_flowing   = i_start_req ? 1'b0 : r_flowing;
            n_save      = 1'b0;
            n_sampled   = 1'b0;
            n_final     = i_finalize;
        end
        if (i_cmd.sample_zero) begin
            n_flow      = '0;
            n_flowing   = 1'b0;
            n_ms_sample = '0;
            n_pending   = '0;
            n_sampled   = 1'b1;
        end
        if (i_cmd.rate_wb) begin
            n_flow = r_ovf ? '1 : r_quo[FLOW_W-1:0];
        end
        if (i_cmd.vol_wb) begin
            n_session   = (r_ovf || (sess_sum[TOT_W:SESS_W] != '0)) ? '1
                                                                   : sess_sum[SESS_W-1:0];
            n_total     = (r_ovf || tot_sum[TOT_W]) ? '1 : tot_sum[TOT_W-1:0];
            n_flowing   = 1'b1;
            n_ms_sample = '0;
            n_pending   = '0;
            n_sampled   = 1'b1;
            if (r_ms_save >= r_cfg_save) begin
                n_save    = 1'b1;
                n_ms_save = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_ms_sample <= '0;
            r_ms_save   <= '0;
            r_flow      <= '0;
            r_session   <= '0;
            r_total     <= '0;
            r_flowing   <= 1'b0;
            r_save      <= 1'b0;
            r_sampled   <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_ms_sample <= n_ms_sample;
            r_ms_save   <= n_ms_save;
            r_flow      <= n_flow;
            r_session   <= n_session;
            r_total     <= n_total;
            r_flowing   <= n_flowing;
            r_save      <= n_save;
            r_sampled   <= n_sampled;
            r_final     <= n_final;
        end
    end

    assign rate_prod = RATE_DVD_W'(r_pending) * RATE_DVD_W'(RATE_SCALE);
    assign vol_prod  = VOL_DVD_W'(r_pending) * VOL_DVD_W'(VOL_SCALE);
    assign den_prod  = DEN_W'(r_ms_sample) * DEN_W'(cal_eff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_rate_dvd <= rate_prod;
            r_vol_dvd  <= vol_prod;
            r_denom    <= den_prod;
        end
    end

    // Restoring division, one quotient bit per cycle. The high dividend bits seed the
    // remainder; if they already reach the divisor the quotient saturates.
    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            if (i_cmd.div_sel == DIV_RATE) begin
                r_div <= r_denom;
                r_rem <= DEN_W'(r_rate_dvd[RATE_DVD_W-1:FLOW_W]);
                r_quo <= {r_rate_dvd[FLOW_W-1:0], {(QUO_W - FLOW_W){1'b0}}};
                r_ovf <= DEN_W'(r_rate_dvd[RATE_DVD_W-1:FLOW_W]) >= r_denom;
            end else begin
                r_div <= DEN_W'(cal_eff);
                r_rem <= DEN_W'(r_vol_dvd[VOL_DVD_W-1:QUO_W]);
                r_quo <= r_vol_dvd[QUO_W-1:0];
                r_ovf <= CAL_W'(r_vol_dvd[VOL_DVD_W-1:QUO_W]) >= cal_eff;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_cnt <= (i_cmd.div_sel == DIV_RATE) ? RATE_STEPS : VOL_STEPS;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_o_flow    <= r_flow;
            r_o_session <= r_session;
            r_o_total   <= r_total;
            r_o_flowing <= r_flowing;
            r_o_save    <= r_save | r_final;
            r_o_sampled <= r_sampled;
        end
    end

    // A zero period behaves as one millisecond, and the counter is at least one here.
    assign o_sts.sample_due = r_ms_sample >= r_cfg_period;
    assign o_sts.pulses_nz  = |r_pending;
    assign o_sts.div_done   = (r_cnt == '0);

    assign o_flow_milli_lpm = r_o_flow;
    assign o_session_ul     = r_o_session;
    assign o_total_ul       = r_o_total;
    assign o_is_flowing     = r_o_flowing;
    assign o_save_request   = r_o_save;
    assign o_sample_taken   = r_o_sampled;

endmodule

/* design/pfm_ctrl.sv */
// Controller state machine of the pulse flow meter, sequencing the datapath per request.
module pfm_ctrl import pfm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.div_sel = DIV_RATE;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_sts.sample_due) begin
                    n_state = S_FINISH;
                end else if (!i_sts.pulses_nz) begin
                    o_cmd.sample_zero = 1'b1;
                    n_state           = S_FINISH;
                end else begin
                    o_cmd.mult = 1'b1;
                    n_state    = S_RATE_LOAD;
                end
            end
            S_RATE_LOAD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = DIV_RATE;
                n_state        = S_RATE_DIV;
            end
            S_RATE_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.rate_wb  = 1'b1;
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = DIV_VOL;
                    n_state        = S_VOL_DIV;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_VOL_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.vol_wb = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sim/tb.sv */
// Self-checking testbench for pulse_flow_meter with random and directed ticks.
module tb import pfm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] DEFAULT_CAL = 64'd4500;
    localparam logic [63:0] SESS_MAX    = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] TOT_MAX     = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] WORD_MAX    = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [EDGE_W-1:0] edges;
        logic              start;
        logic              clear_session;
        logic              finalize;
    } t_tick;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic [SESS_W-1:0] session;
        logic [TOT_W-1:0]  total;
        logic              flowing;
        logic              save;
        logic              sampled;
    } t_reading;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [EDGE_W-1:0]    i_pulse_edges = '0;
    logic                 i_start_req = 1'b0;
    logic                 i_reset_session = 1'b0;
    logic                 i_finalize = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [FLOW_W-1:0]    o_flow_milli_lpm;
    logic [SESS_W-1:0]    o_session_ul;
    logic [TOT_W-1:0]     o_total_ul;
    logic                 o_is_flowing;
    logic                 o_save_request;
    logic                 o_sample_taken;

    pulse_flow_meter i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pulse_edges    (i_pulse_edges),
        .i_start_req      (i_start_req),
        .i_reset_session  (i_reset_session),
        .i_finalize       (i_finalize),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_flow_milli_lpm (o_flow_milli_lpm),
        .o_session_ul     (o_session_ul),
        .o_total_ul       (o_total_ul),
        .o_is_flowing     (o_is_flowing),
        .o_save_request   (o_save_request),
        .o_sample_taken   (o_sample_taken)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Model copy of the configuration registers and the meter state.
    logic [CAL_W-1:0]   cal_q = CAL_RESET;
    logic [PER_W-1:0]   period_q = PERIOD_RESET;
    logic [SAVE_W-1:0]  save_iv_q = SAVE_RESET;
    logic [TOT_W-1:0]   init_q = '0;
    logic [PULSE_W-1:0] acc_q = '0;
    logic [PER_W-1:0]   since_sample_q = '0;
    logic [SAVE_W-1:0]  since_save_q = '0;
    logic [FLOW_W-1:0]  rate_q = '0;
    logic [SESS_W-1:0]  sess_q = '0;
    logic [TOT_W-1:0]   life_q = '0;
    logic               flow_q = 1'b0;

    t_tick       tick_backlog[$];
    t_reading    expected_readings[$];
    t_tick       offered;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned idle_odds = 0;
    int unsigned queued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned received_cnt = 0;
    int unsigned mismatch_cnt = 0;
    bit          quiet_tail = 1'b0;
    logic        drain_hold = 1'b0;

    function automatic t_reading meter_step(input t_tick t);
        t_reading    r;
        logic [63:0] pulses;
        logic [63:0] elapsed;
        logic [63:0] cal;
        logic [63:0] quot;
        logic [63:0] vol;
        logic [63:0] sum;
        logic [63:0] period;
        r = '0;
        if (t.start) begin
            life_q = init_q;
            acc_q = '0;
            since_sample_q = '0;
            since_save_q = '0;
            rate_q = '0;
            sess_q = '0;
            flow_q = 1'b0;
        end
        if (t.clear_session) begin
            sess_q = '0;
            rate_q = '0;
            acc_q = '0;
        end
        pulses = 64'(acc_q);
        pulses = pulses + 64'(t.edges);
        acc_q = (pulses > WORD_MAX) ? '1 : pulses[PULSE_W-1:0];
        if (since_sample_q != '1) since_sample_q = since_sample_q + 1'b1;
        if (since_save_q != '1) since_save_q = since_save_q + 1'b1;
        period = (period_q == '0) ? 64'd1 : 64'(period_q);
        if (64'(since_sample_q) >= period) begin
            elapsed = 64'(since_sample_q);
            pulses = 64'(acc_q);
            r.sampled = 1'b1;
            since_sample_q = '0;
            acc_q = '0;
            if (pulses != 0) begin
                cal = (cal_q == '0) ? DEFAULT_CAL : 64'(cal_q);
                flow_q = 1'b1;
                quot = (pulses * 64'd600000000) / (elapsed * cal);
                rate_q = (quot > WORD_MAX) ? '1 : quot[FLOW_W-1:0];
                vol = (pulses * 64'd10000000) / cal;
                sum = 64'(sess_q);
                sum = sum + vol;
                sess_q = (sum > SESS_MAX) ? '1 : sum[SESS_W-1:0];
                sum = 64'(life_q);
                sum = sum + vol;
                life_q = (sum > TOT_MAX) ? '1 : sum[TOT_W-1:0];
                if (since_save_q >= save_iv_q) begin
                    r.save = 1'b1;
                    since_save_q = '0;
                end
            end else begin
                rate_q = '0;
                flow_q = 1'b0;
            end
        end
        r.save = r.save | t.finalize;
        r.flow = rate_q;
        r.session = sess_q;
        r.total = life_q;
        r.flowing = flow_q;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_cnt++;
        $display("mismatch on reading %0d: %s got 0x%0h expected 0x%0h",
                 received_cnt, what, got, want);
    endtask

    task automatic check_reading();
        t_reading want;
        if (expected_readings.size() == 0) begin
            flag_mismatch("result with no request pending", '0, '0);
        end else begin
            want = expected_readings.pop_front();
            if (o_flow_milli_lpm !== want.flow)
                flag_mismatch("flow_milli_lpm", 64'(o_flow_milli_lpm), 64'(want.flow));
            if (o_session_ul !== want.session)
                flag_mismatch("session_ul", 64'(o_session_ul), 64'(want.session));
            if (o_total_ul !== want.total)
                flag_mismatch("total_ul", 64'(o_total_ul), 64'(want.total));
            if (o_is_flowing !== want.flowing)
                flag_mismatch("is_flowing", 64'(o_is_flowing), 64'(want.flowing));
            if (o_save_request !== want.save)
                flag_mismatch("save_request", 64'(o_save_request), 64'(want.save));
            if (o_sample_taken !== want.sampled)
                flag_mismatch("sample_taken", 64'(o_sample_taken), 64'(want.sampled));
        end
        received_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_readings.push_back(meter_step(offered));
                accepted_cnt++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (tick_backlog.size() > 0) begin
                    offered = tick_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_pulse_edges <= offered.edges;
                    i_start_req <= offered.start;
                    i_reset_session <= offered.clear_session;
                    i_finalize <= offered.finalize;
                    if (!quiet_tail && $urandom_range(99) < idle_odds)
                        send_gap = $urandom_range(9, 1);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_reading();
            if (drain_hold) begin
                i_out_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(99) < idle_odds) begin
                recv_stall = $urandom_range(8, 0);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so that requests back up and the input stalls.
    initial begin
        wait (accepted_cnt >= 60);
        @(posedge i_clk);
        drain_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        drain_hold <= 1'b0;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic queue_tick(input logic [EDGE_W-1:0] edges, input logic start,
                              input logic clear_session, input logic finalize);
        tick_backlog.push_back('{edges, start, clear_session, finalize});
        queued_cnt++;
    endtask

    task automatic wait_drained();
        while (received_cnt != queued_cnt) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] cal, input logic [CFG_W-1:0] per,
                                  input logic [CFG_W-1:0] save_iv,
                                  input logic [CFG_W-1:0] init);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_CAL;
        i_cfg_data <= cal;
        @(posedge i_clk);
        i_cfg_idx <= CFG_PERIOD;
        i_cfg_data <= per;
        @(posedge i_clk);
        i_cfg_idx <= CFG_SAVE;
        i_cfg_data <= save_iv;
        @(posedge i_clk);
        i_cfg_idx <= CFG_INIT;
        i_cfg_data <= init;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cal_q = cal[CAL_W-1:0];
        period_q = per[PER_W-1:0];
        save_iv_q = save_iv[SAVE_W-1:0];
        init_q = init[TOT_W-1:0];
    endtask

    task automatic random_settings();
        logic [CFG_W-1:0] cal;
        logic [CFG_W-1:0] per;
        logic [CFG_W-1:0] save_iv;
        logic [CFG_W-1:0] init;
        case ($urandom_range(3))
            0: cal = CFG_W'($urandom_range(65535));
            1: cal = CFG_W'($urandom_range(50, 1));
            2: cal = '0;
            default: cal = CFG_W'($urandom_range(9000, 1000));
        endcase
        per = ($urandom_range(7) == 0) ? '0 : CFG_W'($urandom_range(12, 1));
        save_iv = CFG_W'($urandom_range(60));
        init[47:32] = 16'($urandom_range(65535));
        init[31:0] = $urandom;
        apply_settings(cal, per, save_iv, init);
    endtask

    // Mostly well-formed metering: flowing and dry spells with rare control
    // flags, plus a share of requests with every field random.
    task automatic run_random_phase(input int unsigned n);
        int unsigned spell;
        bit          dry;
        logic [3:0]  edges;
        spell = 0;
        dry = 1'b0;
        repeat (n) begin
            if (spell == 0) begin
                dry = ($urandom_range(3) == 0);
                spell = $urandom_range(30, 1);
            end
            spell--;
            edges = 4'($urandom_range(15));
            if ($urandom_range(9) == 0)
                queue_tick(edges, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            else
                queue_tick(dry ? 4'd0 : edges, $urandom_range(99) < 2,
                           $urandom_range(99) < 3, $urandom_range(99) < 5);
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_odds = 15;

        queue_tick(4'd0, 1'b0, 1'b0, 1'b0);
        queue_tick(4'd15, 1'b0, 1'b0, 1'b1);
        queue_tick(4'd5, 1'b0, 1'b1, 1'b0);
        queue_tick(4'd3, 1'b1, 1'b0, 1'b0);
        wait_drained();

        apply_settings(48'd1, 48'd1, 48'd0, 48'd0);
        queue_tick(4'd15, 1'b0, 1'b0, 1'b0);
        queue_tick(4'd0, 1'b0, 1'b0, 1'b0);
        queue_tick(4'd1, 1'b0, 1'b0, 1'b0);
        queue_tick(4'd8, 1'b0, 1'b0, 1'b1);
        queue_tick(4'd4, 1'b0, 1'b1, 1'b0);
        queue_tick(4'd2, 1'b1, 1'b0, 1'b0);
        queue_tick(4'd15, 1'b1, 1'b1, 1'b1);
        queue_tick(4'd0, 1'b0, 1'b0, 1'b1);
        wait_drained();

        apply_settings(48'd0, 48'd0, 48'd1, 48'hFFFF_FFFF_FF00);
        queue_tick(4'd0, 1'b1, 1'b0, 1'b0);
        queue_tick(4'd15, 1'b0, 1'b0, 1'b0);
        queue_tick(4'd15, 1'b0, 1'b0, 1'b0);
        queue_tick(4'd9, 1'b0, 1'b1, 1'b1);
        queue_tick(4'd6, 1'b0, 1'b0, 1'b0);
        wait_drained();

        apply_settings(48'd65535, 48'd65535, 48'd131071, 48'hFFFF_FFFF_FFFF);
        queue_tick(4'd15, 1'b1, 1'b0, 1'b0);
        queue_tick(4'd10, 1'b0, 1'b0, 1'b1);
        queue_tick(4'd0, 1'b0, 1'b1, 1'b0);
        wait_drained();

        idle_odds = 20;
        random_settings();
        run_random_phase(150);
        idle_odds = 0;
        random_settings();
        run_random_phase(120);
        idle_odds = 35;
        random_settings();
        run_random_phase(150);

        // Full-rate flow at the smallest calibration, where the flow rate saturates.
        idle_odds = 10;
        apply_settings(48'd1, 48'd20, 48'd40, 48'd0);
        queue_tick(4'd15, 1'b1, 1'b0, 1'b0);
        repeat (80) queue_tick(4'd15, 1'b0, 1'b0, 1'b0);
        wait_drained();

        idle_odds = 20;
        random_settings();
        run_random_phase(150);

        quiet_tail = 1'b1;
        random_settings();
        run_random_phase(80);

        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_readings.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
